### rtl/rws_pkg.sv
// ----------------------------------------------------------------------------
// rws_pkg
// Shared types, codes and constants of the roulette-wheel selection block.
// ----------------------------------------------------------------------------
package rws_pkg;

   // Default sizes of the fitness table
   localparam int MAX_ENTRIES_DEF  = 1024;
   localparam int FITNESS_BITS_DEF = 16;

   // Field widths of the words and the register port
   localparam int OP_W       = 2;
   localparam int INDEX_W    = 10;
   localparam int FIT_W      = 16;
   localparam int SUM_W      = 32;
   localparam int GROUP_W    = 11;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 16;

   // Operation codes
   localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
   localparam logic [OP_W-1:0] OP_SELECT = 2'd1;
   localparam logic [OP_W-1:0] OP_TOTAL  = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_GROUP_SIZE    = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WORST_FITNESS = 4'd1;

   // Register reset values
   localparam logic [GROUP_W-1:0] GROUP_SIZE_RESET    = 11'd2;
   localparam logic [FIT_W-1:0]   WORST_FITNESS_RESET = 16'd0;

   // Range M = (19g [+19]) / 20, the division done as multiply by 2^20/20 rounded up
   localparam int              RANGE_X_W   = 16;
   localparam int              RANGE_P_W   = 33;
   localparam logic [15:0]     RANGE_NUM   = 16'd19;
   localparam logic [32:0]     RANGE_RECIP = 33'd52429;
   localparam int              RANGE_SHIFT = 20;

   // Saturation limit of weights and sums
   localparam logic [SUM_W-1:0] SUM_LIMIT = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [OP_W-1:0]    operation;
      logic [INDEX_W-1:0] entry_index;
      logic [FIT_W-1:0]   fitness_value;
      logic [SUM_W-1:0]   random_value;
      logic               use_short_range;
   } req_type;

   typedef struct packed {
      logic [INDEX_W-1:0] selected_index;
      logic [SUM_W-1:0]   total_weight;
      logic               saturated;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic accept;
      logic range_mul;
      logic range_cap;
      logic walk;
      logic publish;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic walk_done;
   } status_type;

endpackage

### rtl/rws_dpath.sv
// ----------------------------------------------------------------------------
// rws_dpath
// Fitness table, range calculation, weight pipeline, accumulator and
// result word register.
// ----------------------------------------------------------------------------
module rws_dpath #(
   parameter int MAX_ENTRIES  = rws_pkg::MAX_ENTRIES_DEF,
   parameter int FITNESS_BITS = rws_pkg::FITNESS_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  rws_pkg::req_type               req_data,
   input  rws_pkg::cmd_type               cmd,
   output rws_pkg::status_type            status,
   input  logic                           csr_valid,
   input  logic [rws_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rws_pkg::CSR_DATA_W-1:0] csr_wdata,
   output rws_pkg::rsp_type               rsp_data
);

   localparam int ADDR_W = $clog2(MAX_ENTRIES);
   localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
   localparam int SQ_W   = 2 * FITNESS_BITS;

   // Configuration registers
   logic [rws_pkg::GROUP_W-1:0] group_ff;
   logic [rws_pkg::FIT_W-1:0]   worst_ff;

   // Captured request
   logic [rws_pkg::OP_W-1:0]  op_ff;
   logic [rws_pkg::SUM_W-1:0] rnd_ff;
   logic                      short_ff;

   // Table
   logic [FITNESS_BITS-1:0] mem [MAX_ENTRIES];
   logic [FITNESS_BITS-1:0] rd_data_ff;
   logic [31:0]             wr_idx_ext;
   logic [31:0]             wr_fit_ext;
   logic                    mem_we;

   // Range
   logic [rws_pkg::RANGE_X_W-1:0] range_x;
   logic [rws_pkg::RANGE_P_W-1:0] prod_ff;
   logic [31:0]                   m_raw32;
   logic [31:0]                   m_cap32;
   logic [CNT_W-1:0]              m_ff;

   // Walk pipeline
   logic [CNT_W-1:0]        addr_ff;
   logic                    issue;
   logic [3:0]              pv_ff;
   logic [CNT_W-1:0]        idx_ff [4];
   logic [31:0]             worst_ext;
   logic [FITNESS_BITS-1:0] worst_w;
   logic [FITNESS_BITS-1:0] diff_ff;
   logic [SQ_W-1:0]         sq_ff;
   logic [63:0]             sq_plus;
   logic                    wclamp;
   logic [rws_pkg::SUM_W-1:0] wt_ff;
   logic                    wclamp_ff;

   // Accumulator and results
   logic [rws_pkg::SUM_W-1:0] acc_ff;
   logic [rws_pkg::SUM_W:0]   sum_wide;
   logic                      sum_ovf;
   logic [rws_pkg::SUM_W-1:0] next_sum;
   logic                      step;
   logic                      found;
   logic                      last;
   logic [CNT_W-1:0]          sel_ff;
   logic [31:0]               sel_ext;
   logic                      clamp_ff;
   rws_pkg::rsp_type          rsp_data_ff;

   // Write the configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         group_ff <= rws_pkg::GROUP_SIZE_RESET;
         worst_ff <= rws_pkg::WORST_FITNESS_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            rws_pkg::CSR_GROUP_SIZE: begin
               group_ff <= csr_wdata[rws_pkg::GROUP_W-1:0];
            end
            rws_pkg::CSR_WORST_FITNESS: begin
               worst_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // Hold the request fields for the walk
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff    <= req_data.operation;
         rnd_ff   <= req_data.random_value;
         short_ff <= req_data.use_short_range;
      end
   end

   // Table write on load, registered read at the walk address
   assign wr_idx_ext = 32'(req_data.entry_index);
   assign wr_fit_ext = 32'(req_data.fitness_value);
   assign mem_we     = cmd.accept && (req_data.operation == rws_pkg::OP_LOAD) &&
                       (wr_idx_ext < 32'(MAX_ENTRIES));

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_idx_ext[ADDR_W-1:0]] <= wr_fit_ext[FITNESS_BITS-1:0];
      end
      rd_data_ff <= mem[addr_ff[ADDR_W-1:0]];
   end

   // Range: multiply by the reciprocal, then cap at the table size
   assign range_x = 16'(group_ff) * rws_pkg::RANGE_NUM +
                    (short_ff ? 16'd0 : rws_pkg::RANGE_NUM);
   assign m_raw32 = 32'(prod_ff >> rws_pkg::RANGE_SHIFT);
   assign m_cap32 = (m_raw32 > 32'(MAX_ENTRIES)) ? 32'(MAX_ENTRIES) : m_raw32;

   always_ff @(posedge clock) begin
      if (cmd.range_mul) begin
         prod_ff <= 33'(range_x) * rws_pkg::RANGE_RECIP;
      end
      if (cmd.range_cap) begin
         m_ff <= m_cap32[CNT_W-1:0];
      end
   end

   // Issue one address a cycle until the range is covered
   assign issue = cmd.walk && (addr_ff < m_ff);

   always_ff @(posedge clock) begin
      if (cmd.range_cap) begin
         addr_ff <= '0;
      end else if (issue) begin
         addr_ff <= addr_ff + CNT_W'(1);
      end
   end

   // Advance the stage valids; drop anything left from an earlier walk
   always_ff @(posedge clock) begin
      if (reset || cmd.accept) begin
         pv_ff <= '0;
      end else begin
         pv_ff <= {pv_ff[2:0], issue};
      end
   end

   // Weight stages: absolute difference, square, add one and clamp
   assign worst_ext = 32'(worst_ff);
   assign worst_w   = worst_ext[FITNESS_BITS-1:0];
   assign sq_plus   = 64'(sq_ff) + 64'd1;
   assign wclamp    = sq_plus > 64'(rws_pkg::SUM_LIMIT);

   always_ff @(posedge clock) begin
      idx_ff[0] <= addr_ff;
      idx_ff[1] <= idx_ff[0];
      idx_ff[2] <= idx_ff[1];
      idx_ff[3] <= idx_ff[2];
      diff_ff   <= (worst_w >= rd_data_ff) ? (worst_w - rd_data_ff) : (rd_data_ff - worst_w);
      sq_ff     <= SQ_W'(diff_ff) * SQ_W'(diff_ff);
      wt_ff     <= wclamp ? rws_pkg::SUM_LIMIT : sq_plus[rws_pkg::SUM_W-1:0];
      wclamp_ff <= wclamp;
   end

   // Accumulate with saturation and test the draw
   assign sum_wide = {1'b0, acc_ff} + {1'b0, wt_ff};
   assign sum_ovf  = sum_wide[rws_pkg::SUM_W];
   assign next_sum = sum_ovf ? rws_pkg::SUM_LIMIT : sum_wide[rws_pkg::SUM_W-1:0];
   assign step     = cmd.walk && pv_ff[3];
   assign found    = (op_ff == rws_pkg::OP_SELECT) && (rnd_ff < next_sum);
   assign last     = idx_ff[3] == (m_ff - CNT_W'(1));

   assign status.walk_done = cmd.walk && ((m_ff == '0) || (step && (found || last)));

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         acc_ff   <= '0;
         sel_ff   <= '0;
         clamp_ff <= 1'b0;
      end else if (step) begin
         acc_ff   <= next_sum;
         sel_ff   <= idx_ff[3];
         clamp_ff <= clamp_ff | wclamp_ff | sum_ovf;
      end
   end

   // Load the result word
   assign sel_ext = 32'(sel_ff);

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         rsp_data_ff.selected_index <= (op_ff == rws_pkg::OP_SELECT) ?
                                       sel_ext[rws_pkg::INDEX_W-1:0] : '0;
         rsp_data_ff.total_weight   <= (op_ff == rws_pkg::OP_TOTAL) ? acc_ff : '0;
         rsp_data_ff.saturated      <= clamp_ff;
      end
   end

   assign rsp_data = rsp_data_ff;

endmodule

### rtl/rws_ctrl.sv
// ----------------------------------------------------------------------------
// rws_ctrl
// Sequencer of the block: takes a request word, steps the range calculation
// and the table walk, and hands the result word to the output register.
// ----------------------------------------------------------------------------
module rws_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [rws_pkg::OP_W-1:0]  req_op,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  rws_pkg::status_type       status,
   output rws_pkg::cmd_type          cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RANGE_MUL,
      ST_RANGE_CAP,
      ST_WALK,
      ST_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      accept;
   logic      publish;

   // Handshakes
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign publish   = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);

   // Commands to the datapath
   always_comb begin
      cmd.accept    = accept;
      cmd.range_mul = (state_ff == ST_RANGE_MUL);
      cmd.range_cap = (state_ff == ST_RANGE_CAP);
      cmd.walk      = (state_ff == ST_WALK);
      cmd.publish   = publish;
   end

   // Next state and output valid
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_op inside {rws_pkg::OP_SELECT, rws_pkg::OP_TOTAL}) begin
                  state_in = ST_RANGE_MUL;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_RANGE_MUL: begin
            state_in = ST_RANGE_CAP;
         end
         ST_RANGE_CAP: begin
            state_in = ST_WALK;
         end
         ST_WALK: begin
            if (status.walk_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (publish) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (publish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Hold state and the output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef NO_ASSERTIONS
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != ST_IDLE))
      else $error("accepted word did not start an operation");

   a_done_to_finish: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_WALK) && status.walk_done) |=> (state_ff == ST_FINISH))
      else $error("walk end not followed by result hand-off");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !publish)
      else $error("pending result word overwritten");
`endif

endmodule

### rtl/roulette_wheel_selection.sv
// ----------------------------------------------------------------------------
// roulette_wheel_selection
// Roulette-wheel selection over a table of fitness values: load an entry,
// report the total weight of the first M entries, or select an index.
//
//   channel  direction  handshake              word
//   req_     in         req_valid / req_ready  rws_pkg::req_type
//   rsp_     out        rsp_valid / rsp_ready  rws_pkg::rsp_type
//   csr_     in         csr_valid / csr_ready  csr_index, csr_wdata
//
// Load and the unused code go from acceptance straight to the finish state;
// select and total step range multiply and cap, then walk: a total covers
// all M entries, a select stops at the chosen index. The walk reads one table
// entry a cycle through the single memory read port, four pipeline stages deep.
// One word is in work at a time; a new word is taken while the result waits.
// Reset is synchronous; the table is not cleared and needs loading before use.
// ----------------------------------------------------------------------------
module roulette_wheel_selection #(
   parameter int MAX_ENTRIES  = rws_pkg::MAX_ENTRIES_DEF,
   parameter int FITNESS_BITS = rws_pkg::FITNESS_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  rws_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output rws_pkg::rsp_type               rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [rws_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rws_pkg::CSR_DATA_W-1:0] csr_wdata
);

   rws_pkg::cmd_type    cmd;
   rws_pkg::status_type status;

   // Registers take a write in any cycle
   assign csr_ready = 1'b1;

   rws_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_op    (req_data.operation),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   rws_dpath #(
      .MAX_ENTRIES  (MAX_ENTRIES),
      .FITNESS_BITS (FITNESS_BITS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_data  (rsp_data)
   );

endmodule

### tb/tb_roulette_wheel_selection.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_roulette_wheel_selection
// Self-checking bench for the roulette-wheel selection block. A scoreboard
// class keeps its own copy of the fitness table and the two registers, works
// out the result of every accepted request word and checks each response
// word against the oldest expectation. Stimulus runs a short directed part,
// fills the low part of the table, then runs random phases under several
// register settings with random idle bursts on both channels.
// ----------------------------------------------------------------------------
module tb_roulette_wheel_selection;
   import rws_pkg::*;

   // Spare operation code and a register index with no register behind it
   localparam logic [OP_W-1:0]      OP_SPARE    = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED  = 4'hF;
   localparam int                   STALL_LIMIT = 20000;
   localparam int                   TABLE_DEPTH = MAX_ENTRIES_DEF;
   localparam int                   FILL_DEPTH  = 200;

   // -------------------------------------------------------------------------
   // Scoreboard: fitness table copy, weight walk and expected responses
   // -------------------------------------------------------------------------
   class wheel_scoreboard;
      logic [FIT_W-1:0]   fit_table [TABLE_DEPTH];
      bit                 loaded [TABLE_DEPTH];
      logic [GROUP_W-1:0] group_size;
      logic [FIT_W-1:0]   worst;
      rsp_type            expected_q [$];
      int                 mismatches;

      function new();
         group_size = GROUP_SIZE_RESET;
         worst      = WORST_FITNESS_RESET;
         mismatches = 0;
         foreach (loaded[i]) loaded[i] = 1'b0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         if (idx == CSR_GROUP_SIZE)
            group_size = data[GROUP_W-1:0];
         else if (idx == CSR_WORST_FITNESS)
            worst = data[FIT_W-1:0];
      endfunction

      // Entries walked: ceiling or floor of 0.95g, capped at the table depth
      function int unsigned span(bit short_range);
         int unsigned g;
         int unsigned m;
         g = 32'(group_size);
         m = short_range ? (19 * g) / 20 : (19 * g + 19) / 20;
         if (m > TABLE_DEPTH) m = TABLE_DEPTH;
         return m;
      endfunction

      function bit range_covered(bit short_range);
         int unsigned m;
         m = span(short_range);
         for (int unsigned i = 0; i < m; i++)
            if (!loaded[i]) return 1'b0;
         return 1'b1;
      endfunction

      // Spin the wheel for one word; loads and the spare code give all zeros
      function rsp_type spin(req_type w);
         rsp_type           r;
         int unsigned       m;
         int unsigned       i;
         longint unsigned   d;
         longint unsigned   wt;
         longint unsigned   run;
         longint unsigned   nxt;
         bit                clamp;
         bit                found;
         r     = '0;
         run   = 0;
         clamp = 1'b0;
         found = 1'b0;
         if (w.operation == OP_SELECT || w.operation == OP_TOTAL) begin
            m = span(w.use_short_range);
            for (i = 0; i < m && !found; i++) begin
               d  = 64'((worst >= fit_table[i]) ? worst - fit_table[i]
                                                : fit_table[i] - worst);
               wt = d * d + 64'd1;
               if (wt > SUM_LIMIT) begin
                  clamp = 1'b1;
                  wt    = 64'(SUM_LIMIT);
               end
               nxt = run + wt;
               if (nxt > SUM_LIMIT) begin
                  clamp = 1'b1;
                  nxt   = 64'(SUM_LIMIT);
               end
               if (w.operation == OP_SELECT && w.random_value < nxt) begin
                  r.selected_index = i[INDEX_W-1:0];
                  found = 1'b1;
               end else begin
                  run = nxt;
               end
            end
            if (w.operation == OP_SELECT && !found)
               r.selected_index = (m == 0) ? '0 : INDEX_W'(m - 1);
            if (w.operation == OP_TOTAL)
               r.total_weight = run[SUM_W-1:0];
            r.saturated = clamp;
         end
         return r;
      endfunction

      function logic [SUM_W-1:0] range_total(bit short_range);
         req_type q;
         rsp_type r;
         q = '0;
         q.operation       = OP_TOTAL;
         q.use_short_range = short_range;
         r = spin(q);
         return r.total_weight;
      endfunction

      // Note an accepted request word
      function void note_word(req_type w);
         expected_q.push_back(spin(w));
         if (w.operation == OP_LOAD) begin
            fit_table[w.entry_index] = w.fitness_value;
            loaded[w.entry_index]    = 1'b1;
         end
      endfunction

      function void check_field(string name, longint unsigned e, longint unsigned a);
         if (e != a) begin
            mismatches++;
            $display("%0t: %s expected %0h actual %0h", $time, name, e, a);
         end
      endfunction

      // Check an accepted response word against the oldest expectation
      function void check_word(rsp_type got);
         rsp_type want;
         if (expected_q.size() == 0) begin
            mismatches++;
            $display("%0t: response expected none actual %0h", $time, got);
         end else begin
            want = expected_q.pop_front();
            check_field("selected_index", want.selected_index, got.selected_index);
            check_field("total_weight", want.total_weight, got.total_weight);
            check_field("saturated", want.saturated, got.saturated);
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_type               rsp_data;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   wheel_scoreboard sb;
   bit              idle_on;
   int              stall_left;
   int              quiet_cycles;

   roulette_wheel_selection dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // -------------------------------------------------------------------------
   // Word builders
   // -------------------------------------------------------------------------
   function automatic req_type word(logic [OP_W-1:0] op, logic [INDEX_W-1:0] idx,
                                    logic [FIT_W-1:0] fit, logic [SUM_W-1:0] rnd,
                                    logic short_range);
      req_type w;
      w.operation       = op;
      w.entry_index     = idx;
      w.fitness_value   = fit;
      w.random_value    = rnd;
      w.use_short_range = short_range;
      return w;
   endfunction

   // Fitness close to the current worst value, so that weights stay small
   function automatic logic [FIT_W-1:0] near_worst();
      int v;
      v = int'(sb.worst) + int'($urandom_range(0, 40)) - 20;
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      return v[FIT_W-1:0];
   endfunction

   function automatic req_type random_word();
      req_type          w;
      int unsigned      pick;
      logic [SUM_W-1:0] total;
      w.operation       = OP_LOAD;
      w.entry_index     = INDEX_W'($urandom_range(0, TABLE_DEPTH - 1));
      w.fitness_value   = FIT_W'($urandom_range(0, 65535));
      w.random_value    = $urandom;
      w.use_short_range = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
         if ($urandom_range(0, 99) < 85) w.fitness_value = near_worst();
      end else if (pick < 95) begin
         // Fall back to a load if the range would touch an unwritten entry
         if (sb.range_covered(w.use_short_range)) begin
            w.operation = (pick < 80) ? OP_SELECT : OP_TOTAL;
            total = sb.range_total(w.use_short_range);
            pick  = $urandom_range(0, 99);
            if (pick < 15)
               w.random_value = '0;
            else if (pick < 25)
               w.random_value = SUM_LIMIT;
            else if (pick < 85 && total != 0)
               w.random_value = $urandom_range(0, total - 1);
         end else begin
            w.fitness_value = near_worst();
         end
      end else begin
         w.operation = OP_SPARE;
      end
      return w;
   endfunction

   // -------------------------------------------------------------------------
   // Drivers
   // -------------------------------------------------------------------------
   // Present one request word; valid stays high on return for the next word
   task automatic send_word(req_type w);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_word(w);
   endtask

   // Wait until every response is back and the block has gone quiet
   task automatic settle();
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write both registers, and a stray index if asked
   task automatic configure(logic [CSR_DATA_W-1:0] group_word,
                            logic [CSR_DATA_W-1:0] worst_word, bit stray);
      logic [CSR_IDX_W-1:0]  idx;
      logic [CSR_DATA_W-1:0] data;
      for (int k = 0; k < (stray ? 3 : 2); k++) begin
         idx  = (k == 0) ? CSR_GROUP_SIZE : (k == 1) ? CSR_WORST_FITNESS : CSR_UNUSED;
         data = (k == 0) ? group_word : (k == 1) ? worst_word : CSR_DATA_W'($urandom);
         csr_valid <= 1'b1;
         csr_index <= idx;
         csr_wdata <= data;
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         sb.set_register(idx, data);
      end
      csr_valid <= 1'b0;
   endtask

   // Group size word with junk in the bits above the register
   function automatic logic [CSR_DATA_W-1:0] group_word(int unsigned g);
      logic [CSR_DATA_W-1:0] v;
      v = CSR_DATA_W'($urandom);
      v[GROUP_W-1:0] = g[GROUP_W-1:0];
      return v;
   endfunction

   task automatic run_phase(int unsigned g, logic [FIT_W-1:0] worst_word, int count);
      settle();
      configure(group_word(g), worst_word, $urandom_range(0, 3) == 0);
      repeat (count) send_word(random_word());
      req_valid <= 1'b0;
   endtask

   task automatic run_directed();
      // Reset settings, g = 2: saturation, fitness above worst, spare code
      send_word(word(OP_LOAD, 10'd0, 16'hFFFF, '0, 1'b0));
      send_word(word(OP_LOAD, 10'd1, 16'hFFFF, '0, 1'b1));
      send_word(word(OP_TOTAL, '0, '0, '0, 1'b0));
      send_word(word(OP_TOTAL, '0, '0, '0, 1'b1));
      send_word(word(OP_SELECT, '0, '0, SUM_LIMIT, 1'b0));
      send_word(word(OP_SELECT, '0, '0, '0, 1'b0));
      send_word(word(OP_SELECT, '0, '0, SUM_LIMIT, 1'b1));
      send_word(word(OP_SPARE, 10'h3FF, 16'hFFFF, SUM_LIMIT, 1'b1));
      send_word(word(OP_LOAD, 10'h3FF, 16'h0000, SUM_LIMIT, 1'b0));
      send_word(word(OP_LOAD, 10'd0, 16'h0000, '0, 1'b0));
      send_word(word(OP_LOAD, 10'd1, 16'h0000, '0, 1'b0));
      send_word(word(OP_TOTAL, '0, '0, '0, 1'b0));
      send_word(word(OP_SELECT, '0, '0, 32'd1, 1'b0));
      req_valid <= 1'b0;
      // Empty range
      settle();
      configure(group_word(0), 16'hFFFF, 1'b1);
      send_word(word(OP_TOTAL, '0, '0, '0, 1'b0));
      send_word(word(OP_SELECT, '0, '0, $urandom, 1'b1));
      send_word(word(OP_SELECT, '0, '0, '0, 1'b0));
      req_valid <= 1'b0;
      // One entry in the ceiling range, none in the floor range
      settle();
      configure(group_word(1), 16'hFFFF, 1'b0);
      send_word(word(OP_TOTAL, '0, '0, '0, 1'b0));
      send_word(word(OP_TOTAL, '0, '0, '0, 1'b1));
      send_word(word(OP_SELECT, '0, '0, SUM_LIMIT, 1'b0));
      send_word(word(OP_SELECT, '0, '0, '0, 1'b1));
      req_valid <= 1'b0;
   endtask

   // -------------------------------------------------------------------------
   // Response side: random stall bursts, check every accepted word
   // -------------------------------------------------------------------------
   initial begin
      rsp_ready  <= 1'b0;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) sb.check_word(rsp_data);
         if (stall_left != 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = int'($urandom_range(1, 15)) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog: count cycles with no handshake on any channel
   initial begin
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      sb        = new();
      idle_on   = 1'b1;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();

      // Fill the low part of the table so that ranges up to its size can be walked
      settle();
      configure(group_word(2), 16'h8000, 1'b0);
      for (int i = 0; i < FILL_DEPTH; i++)
         send_word(word(OP_LOAD, i[INDEX_W-1:0], near_worst(), $urandom,
                        1'($urandom_range(0, 1))));
      req_valid <= 1'b0;

      // Random phases: one at the largest filled size, most small
      run_phase(210, 16'h8000, 20);
      run_phase(2, 16'hFFFF, 20);
      for (int p = 0; p < 6; p++)
         run_phase($urandom_range(2, 48),
                   ($urandom_range(0, 2) == 0) ? FIT_W'($urandom) : near_worst(), 20);
      // Last stretch without idling
      settle();
      idle_on = 1'b0;
      run_phase($urandom_range(2, 32), 16'h8000, 40);

      settle();
      repeat (20) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
